FILE: design/cantx_pkg.sv
// shared types and constants for the can transmit register block
`default_nettype none
package cantx_pkg;

  // address region size; the 7-bit address always falls inside it
  localparam int REGION_BYTES = 128;

  localparam int ADDR_W   = 7;
  localparam int BUF_DEPTH = 13;
  localparam int ACC_DEPTH = 8;
  localparam int MAX_LEN  = 8;

  // register addresses
  localparam logic [ADDR_W-1:0] ADDR_MODE     = 7'd0;
  localparam logic [ADDR_W-1:0] ADDR_COMMAND  = 7'd1;
  localparam logic [ADDR_W-1:0] ADDR_STATUS   = 7'd2;
  localparam logic [ADDR_W-1:0] ADDR_BUF_LO   = 7'd16;
  localparam logic [ADDR_W-1:0] ADDR_ACC_HI   = 7'd23;
  localparam logic [ADDR_W-1:0] ADDR_BUF_HI   = 7'd28;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_CLR  = 7'd127;

  localparam logic [7:0] MODE_MASK     = 8'h1f;
  localparam logic [7:0] IRQ_CLR_KEY   = 8'h33;
  localparam logic [7:0] STATUS_VALUE  = 8'h0c;
  localparam logic [7:0] READ_DEFAULT  = 8'hff;
  localparam logic [4:0] MODE_RESET    = 5'h01;

  localparam int HEAD_RTR_BIT = 6;
  localparam int HEAD_EXT_BIT = 7;
  localparam int ID_RTR_BIT   = 30;
  localparam int ID_EXT_BIT   = 31;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_SEND  = 2'd2
  } kind_t;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [31:0] id;
    logic [3:0]  len;
    logic [63:0] data;
  } frame_t;

endpackage
`default_nettype wire

FILE: design/can_controller_tx_registers_top.sv
// top level of the can controller transmit register block
`default_nettype none
// Byte-wide register port of a CAN controller's transmit side. Each access
// beat (cmd, addr, wdata) gives exactly one registered reply beat, and a
// new access can be taken every cycle: register state is
// updated at the accepting edge and the reply goes into an output register,
// so the next access already sees the effect of the previous one. The input
// ready only drops while a reply sits in the output register and the
// downstream side holds off. Writes to address 0 set the 5-bit mode (bit 0
// set means reset mode, the state after rst). Writes to 16..28 fill the
// 13-byte transmit buffer in operating mode, or bytes 16..23 go to the
// acceptance code in reset mode. Writing a byte with bit 0 set to address 1
// packs the buffer into a frame (kind 2 reply carrying id, length and data)
// and raises the interrupt; writing 0x33 to address 127 lowers it. Reads
// return the mode at 0, the fixed status 0x0c at 2, and 0xff elsewhere.
// The frame fields and rdata are zero whenever they do not apply, and
// irq_level shows the interrupt line after the access.
module can_controller_tx_registers_top (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         cmd,
  input  wire  [6:0]  addr,
  input  wire  [7:0]  wdata,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  rdata,
  output logic [31:0] frame_id,
  output logic [3:0]  frame_len,
  output logic [63:0] frame_data,
  output logic        irq_level
);
  import cantx_pkg::*;

  // architectural state
  logic [4:0] mode_reg;
  byte_t      accept_code [ACC_DEPTH];
  byte_t      xfer_buffer [BUF_DEPTH];
  logic       irq_line;

  logic       accept;
  logic       in_region;
  logic       is_write;
  logic       send;
  logic       buf_hit;
  logic [3:0] buf_idx;
  logic       irq_next;
  kind_t      kind_next;
  byte_t      rdata_next;
  frame_t     frame;

  // output register frees up when empty or being drained
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign in_region = {6'd0, addr} <= 13'(REGION_BYTES);
  assign is_write  = (cmd == CMD_WRITE) && in_region;
  assign send      = is_write && (addr == ADDR_COMMAND) && wdata[0];
  assign buf_hit   = is_write && (addr >= ADDR_BUF_LO) && (addr <= ADDR_BUF_HI);
  assign buf_idx   = 4'(addr - ADDR_BUF_LO);

  cantx_frame_pack u_pack (
    .buf_bytes (xfer_buffer),
    .frame     (frame)
  );

  // interrupt: send raises, the clear key lowers
  always_comb begin
    irq_next = irq_line;
    if (send) begin
      irq_next = 1'b1;
    end else if (is_write && addr == ADDR_IRQ_CLR && wdata == IRQ_CLR_KEY) begin
      irq_next = 1'b0;
    end
  end

  // reply kind and read data
  always_comb begin
    rdata_next = '0;
    if (cmd == CMD_READ) begin
      kind_next = KIND_READ;
      if (!in_region) begin
        rdata_next = '0;
      end else if (addr == ADDR_MODE) begin
        rdata_next = {3'd0, mode_reg};
      end else if (addr == ADDR_STATUS) begin
        rdata_next = STATUS_VALUE;
      end else begin
        rdata_next = READ_DEFAULT;
      end
    end else if (send) begin
      kind_next = KIND_SEND;
    end else begin
      kind_next = KIND_WRITE;
    end
  end

  // register state, updated at the accepting edge
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg <= MODE_RESET;
      irq_line <= 1'b0;
      for (int i = 0; i < ACC_DEPTH; i++) begin
        accept_code[i] <= '0;
      end
      for (int i = 0; i < BUF_DEPTH; i++) begin
        xfer_buffer[i] <= '0;
      end
    end else if (accept) begin
      irq_line <= irq_next;
      if (is_write && addr == ADDR_MODE) begin
        mode_reg <= 5'(wdata & MODE_MASK);
      end
      if (buf_hit) begin
        if (mode_reg[0]) begin
          // reset mode: only the acceptance code window is writable
          if (addr <= ADDR_ACC_HI) begin
            accept_code[buf_idx[2:0]] <= wdata;
          end
        end else begin
          xfer_buffer[buf_idx] <= wdata;
        end
      end
    end
  end

  // reply beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind       <= kind_next;
      rdata      <= rdata_next;
      irq_level  <= irq_next;
      frame_id   <= send ? frame.id   : '0;
      frame_len  <= send ? frame.len  : '0;
      frame_data <= send ? frame.data : '0;
    end
  end

endmodule
`default_nettype wire

FILE: design/cantx_frame_pack.sv
// packs the transmit buffer bytes into identifier, length and data
`default_nettype none
module cantx_frame_pack (
  input  var cantx_pkg::byte_t  buf_bytes [cantx_pkg::BUF_DEPTH],
  output cantx_pkg::frame_t     frame
);
  import cantx_pkg::*;

  byte_t       head;
  logic        ext;
  logic [3:0]  len;
  logic [31:0] id;
  logic [63:0] data;

  assign head = buf_bytes[0];
  assign ext  = head[HEAD_EXT_BIT];

  // length field saturates at eight bytes
  assign len = (head[3:0] > 4'(MAX_LEN)) ? 4'(MAX_LEN) : head[3:0];

  always_comb begin
    id = '0;
    id[ID_RTR_BIT] = head[HEAD_RTR_BIT];
    if (ext) begin
      id[ID_EXT_BIT] = 1'b1;
      id[28:0] = {buf_bytes[1], buf_bytes[2], buf_bytes[3], buf_bytes[4][7:3]};
    end else begin
      id[10:0] = {buf_bytes[1], buf_bytes[2][7:5]};
    end
  end

  // data starts at byte 5 for extended frames, byte 3 for standard ones
  always_comb begin
    data = '0;
    for (int i = 0; i < MAX_LEN; i++) begin
      if (4'(i) < len) begin
        data[8*i +: 8] = ext ? buf_bytes[5 + i] : buf_bytes[3 + i];
      end
    end
  end

  assign frame = '{id: id, len: len, data: data};

endmodule
`default_nettype wire

FILE: design/cantx_checker.sv
// port-level checks on the transmit register block, bound to the top level
`default_nettype none
module cantx_checker (
  input wire        clk,
  input wire        rst,
  input wire        out_valid,
  input wire        out_ready,
  input wire [1:0]  kind,
  input wire [7:0]  rdata,
  input wire [31:0] frame_id,
  input wire [3:0]  frame_len,
  input wire [63:0] frame_data,
  input wire        irq_level
);
  import cantx_pkg::*;

  // a stalled reply beat holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(rdata)
      && $stable(frame_id) && $stable(frame_len) && $stable(frame_data))
    else $error("reply beat changed while stalled");

  // a sent frame always leaves the interrupt raised and has a length of at most eight
  a_send_irq: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_SEND |-> irq_level && frame_len <= 4'(MAX_LEN))
    else $error("send without interrupt or with bad length");

  // frame fields are zero unless a frame was sent
  a_frame_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_SEND |-> frame_id == '0 && frame_len == '0
      && frame_data == '0)
    else $error("frame fields set on a non-send reply");

  // writes return zero read data, and the reply code is a legal one
  a_write_rdata: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_READ) || (kind == KIND_WRITE && rdata == '0)
      || (kind == KIND_SEND && rdata == '0))
    else $error("bad reply kind or nonzero write data");

  // the interrupt level only rises on a send reply
  a_irq_rise: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready ##1 out_valid && !$past(irq_level) && irq_level
      |-> kind == KIND_SEND)
    else $error("interrupt raised without a frame");

endmodule

bind can_controller_tx_registers_top cantx_checker u_cantx_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .kind       (kind),
  .rdata      (rdata),
  .frame_id   (frame_id),
  .frame_len  (frame_len),
  .frame_data (frame_data),
  .irq_level  (irq_level)
);
`default_nettype wire

FILE: tb/testbench.sv
// self-checking testbench for the can transmit register block: directed table, then random bus traffic
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cantx_pkg::*;

  // run length and pacing
  localparam int          TOTAL_BEATS = 1775;      // directed plus random access beats
  localparam int          LONG_HOLD   = 64;        // long downstream hold-off, in cycles
  localparam int          SETTLE      = 4;         // settling margin after the final drain
  localparam int          RUN_LIMIT_NS = 2_000_000;
  // an address with no register behind it
  localparam logic [ADDR_W-1:0] ADDR_SPARE = 7'd5;

  // one reply beat as the block should present it
  typedef struct packed {
    kind_t  kind;
    byte_t  rdata;
    frame_t frame;
    logic   irq;
  } reply_t;

  // one row of the directed table; known rows carry the reply typed in by hand
  typedef struct packed {
    cmd_t              c;
    logic [ADDR_W-1:0] a;
    byte_t             v;
    logic              known;
    kind_t             k;
    byte_t             rd;
    logic              irq;
  } script_row_t;

  localparam int SCRIPT_LEN = 25;

  logic clk = 1'b0;
  logic rst;

  // access channel
  logic              in_valid;
  logic              in_ready;
  logic              cmd;
  logic [ADDR_W-1:0] addr;
  logic [7:0]        wdata;

  // reply channel
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind;
  logic [7:0]  rdata;
  logic [31:0] frame_id;
  logic [3:0]  frame_len;
  logic [63:0] frame_data;
  logic        irq_level;

  // typed-in expectation travels alongside the access beat it belongs to
  logic   typed_known;
  reply_t typed_reply;

  // flags and counters used by the upstream, downstream and scoreboard processes
  logic        calm;           // no upstream gaps during this sequence
  logic        long_hold_req;  // ask the downstream side for one long hold-off
  int unsigned beats_sent = 0;
  int unsigned mismatches = 0;

  // mirror of the block state, advanced once per accepted access beat
  logic [4:0] cur_mode = MODE_RESET;
  byte_t      acc_code [ACC_DEPTH] = '{default: 8'h00};
  byte_t      tx_bytes [BUF_DEPTH] = '{default: 8'h00};
  logic       irq_mirror = 1'b0;

  // replies still owed by the block, oldest first
  reply_t replies_due [$];

  script_row_t script [SCRIPT_LEN];

  can_controller_tx_registers_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .addr       (addr),
    .wdata      (wdata),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .rdata      (rdata),
    .frame_id   (frame_id),
    .frame_len  (frame_len),
    .frame_data (frame_data),
    .irq_level  (irq_level)
  );

  always #1 clk = ~clk;

  // directed table: reset values, read defaults, reset-mode writes, irq clear key,
  // mode extremes, then frames that need the predictor
  initial begin
    script = '{
      '{CMD_READ,  ADDR_MODE,    8'h00, 1'b1, KIND_READ,  {3'b000, MODE_RESET}, 1'b0},
      '{CMD_READ,  ADDR_STATUS,  8'h00, 1'b1, KIND_READ,  STATUS_VALUE,  1'b0},
      '{CMD_READ,  ADDR_COMMAND, 8'hff, 1'b1, KIND_READ,  READ_DEFAULT,  1'b0},
      '{CMD_READ,  ADDR_IRQ_CLR, 8'h00, 1'b1, KIND_READ,  READ_DEFAULT,  1'b0},
      // reset mode: buffer addresses land in the acceptance code
      '{CMD_WRITE, ADDR_BUF_LO,  8'haa, 1'b1, KIND_WRITE, 8'h00, 1'b0},
      '{CMD_WRITE, ADDR_ACC_HI,  8'hff, 1'b1, KIND_WRITE, 8'h00, 1'b0},
      // reset mode: upper buffer addresses are dropped
      '{CMD_WRITE, 7'(ADDR_ACC_HI + 7'd1), 8'h55, 1'b1, KIND_WRITE, 8'h00, 1'b0},
      '{CMD_WRITE, ADDR_BUF_HI,  8'h00, 1'b1, KIND_WRITE, 8'h00, 1'b0},
      // send in reset mode from a cleared buffer gives an all-zero frame
      '{CMD_WRITE, ADDR_COMMAND, 8'h01, 1'b1, KIND_SEND,  8'h00, 1'b1},
      // wrong clear key leaves the interrupt up, right key drops it
      '{CMD_WRITE, ADDR_IRQ_CLR, 8'h32, 1'b1, KIND_WRITE, 8'h00, 1'b1},
      '{CMD_WRITE, ADDR_IRQ_CLR, IRQ_CLR_KEY, 1'b1, KIND_WRITE, 8'h00, 1'b0},
      '{CMD_WRITE, ADDR_MODE,    8'hff, 1'b1, KIND_WRITE, 8'h00, 1'b0},
      '{CMD_READ,  ADDR_MODE,    8'h00, 1'b1, KIND_READ,  MODE_MASK, 1'b0},
      '{CMD_WRITE, ADDR_MODE,    8'h00, 1'b1, KIND_WRITE, 8'h00, 1'b0},
      // operating mode: extended remote frame with length over eight
      '{CMD_WRITE, ADDR_BUF_LO,  8'hcf, 1'b0, KIND_READ, 8'h00, 1'b0},
      '{CMD_WRITE, 7'(ADDR_BUF_LO + 7'd1), 8'hff, 1'b0, KIND_READ, 8'h00, 1'b0},
      '{CMD_WRITE, 7'(ADDR_BUF_LO + 7'd4), 8'hff, 1'b0, KIND_READ, 8'h00, 1'b0},
      '{CMD_WRITE, ADDR_BUF_HI,  8'hee, 1'b0, KIND_READ, 8'h00, 1'b0},
      '{CMD_WRITE, ADDR_COMMAND, 8'hff, 1'b0, KIND_READ, 8'h00, 1'b0},
      // send again while the interrupt is still raised
      '{CMD_WRITE, ADDR_COMMAND, 8'h01, 1'b0, KIND_READ, 8'h00, 1'b0},
      // standard frame, full length; command without bit 0 does nothing
      '{CMD_WRITE, ADDR_BUF_LO,  8'h08, 1'b0, KIND_READ, 8'h00, 1'b0},
      '{CMD_WRITE, ADDR_COMMAND, 8'hfe, 1'b0, KIND_READ, 8'h00, 1'b0},
      '{CMD_WRITE, ADDR_COMMAND, 8'h01, 1'b0, KIND_READ, 8'h00, 1'b0},
      '{CMD_WRITE, ADDR_SPARE,   8'ha5, 1'b0, KIND_READ, 8'h00, 1'b0},
      '{CMD_READ,  ADDR_SPARE,   8'h00, 1'b0, KIND_READ, 8'h00, 1'b0}
    };
  end

  // predicted reply for one access; also advances the mirrored state
  function automatic reply_t apply_access(cmd_t c, logic [ADDR_W-1:0] a, byte_t v);
    reply_t      r;
    byte_t       head;
    int unsigned n;
    int unsigned base;
    r = '0;
    r.kind = KIND_WRITE;
    if (c == CMD_READ) begin
      r.kind = KIND_READ;
      if (a == ADDR_MODE) r.rdata = {3'b000, cur_mode};
      else if (a == ADDR_STATUS) r.rdata = STATUS_VALUE;
      else r.rdata = READ_DEFAULT;
    end else if (a == ADDR_MODE) begin
      cur_mode = 5'(v & MODE_MASK);
    end else if (a == ADDR_COMMAND) begin
      if (v[0]) begin
        head = tx_bytes[0];
        n = (head[3:0] > MAX_LEN) ? MAX_LEN : head[3:0];
        if (head[HEAD_EXT_BIT]) begin
          r.frame.id = (32'(tx_bytes[1]) << 21) | (32'(tx_bytes[2]) << 13) |
                       (32'(tx_bytes[3]) << 5) | 32'(tx_bytes[4] >> 3);
          r.frame.id[ID_EXT_BIT] = 1'b1;
          base = 5;
        end else begin
          r.frame.id = (32'(tx_bytes[1]) << 3) | 32'(tx_bytes[2] >> 5);
          base = 3;
        end
        r.frame.id[ID_RTR_BIT] = head[HEAD_RTR_BIT];
        r.frame.len = 4'(n);
        for (int i = 0; i < n; i++) r.frame.data[8*i +: 8] = tx_bytes[base + i];
        irq_mirror = 1'b1;
        r.kind = KIND_SEND;
      end
    end else if (a >= ADDR_BUF_LO && a <= ADDR_BUF_HI) begin
      if (cur_mode[0]) begin
        if (a <= ADDR_ACC_HI) acc_code[a - ADDR_BUF_LO] = v;
      end else begin
        tx_bytes[a - ADDR_BUF_LO] = v;
      end
    end else if (a == ADDR_IRQ_CLR && v == IRQ_CLR_KEY) begin
      irq_mirror = 1'b0;
    end
    r.irq = irq_mirror;
    return r;
  endfunction

  function automatic void compare_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // present one access beat and hold it until the block takes it;
  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer(input cmd_t c, input logic [ADDR_W-1:0] a, input byte_t v,
                       input logic known, input reply_t typed);
    int unsigned gap;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= c;
    addr        <= a;
    wdata       <= v;
    typed_known <= known;
    typed_reply <= typed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic access(input cmd_t c, input logic [ADDR_W-1:0] a, input byte_t v);
    offer(c, a, v, 1'b0, '0);
  endtask

  // stop offering and wait for every owed reply
  task automatic drain_replies();
    in_valid <= 1'b0;
    @(negedge clk);
    while (replies_due.size() != 0) @(negedge clk);
  endtask

  // upstream: reset, directed table, then random sequences
  initial begin : upstream
    int unsigned roll;
    int unsigned n;
    int unsigned seq_no;
    byte_t       head;
    reply_t      typed;
    rst           = 1'b1;
    in_valid      = 1'b0;
    cmd           = CMD_READ;
    addr          = '0;
    wdata         = '0;
    typed_known   = 1'b0;
    typed_reply   = '0;
    calm          = 1'b0;
    long_hold_req = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      typed       = '0;
      typed.kind  = script[i].k;
      typed.rdata = script[i].rd;
      typed.irq   = script[i].irq;
      offer(script[i].c, script[i].a, script[i].v, script[i].known, typed);
    end

    seq_no = 0;
    while (beats_sent < TOTAL_BEATS) begin
      calm = ($urandom_range(0, 4) == 0);
      // downstream stalls for a long stretch while we keep pushing beats
      if (seq_no == 30 || seq_no == 80) begin
        long_hold_req = 1'b1;
        calm = 1'b1;
      end
      // now and then let the block run dry before going on
      if (seq_no % 40 == 20) drain_replies();
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        // well-formed frame: maybe set the mode, fill the buffer, maybe read, send, maybe clear
        n = $urandom_range(0, 5);
        if (n < 3) access(CMD_WRITE, ADDR_MODE, byte_t'($urandom) & ~8'h01);
        else if (n == 3) access(CMD_WRITE, ADDR_MODE, byte_t'($urandom) | 8'h01);
        head = byte_t'($urandom);
        if ($urandom_range(0, 9) < 7) head[3:0] = 4'($urandom_range(0, MAX_LEN));
        access(CMD_WRITE, ADDR_BUF_LO, head);
        for (int k = 1; k < BUF_DEPTH; k++) begin
          if ($urandom_range(0, 9) != 0)
            access(CMD_WRITE, 7'(ADDR_BUF_LO + k), byte_t'($urandom));
        end
        if ($urandom_range(0, 3) == 0)
          access(CMD_READ, 7'($urandom_range(0, 3)), byte_t'($urandom));
        access(CMD_WRITE, ADDR_COMMAND, byte_t'($urandom) | 8'h01);
        if ($urandom_range(0, 1) != 0) access(CMD_WRITE, ADDR_IRQ_CLR, IRQ_CLR_KEY);
      end else if (roll < 75) begin
        // reset mode: acceptance code writes and dropped upper addresses
        access(CMD_WRITE, ADDR_MODE, byte_t'($urandom) | 8'h01);
        n = $urandom_range(3, 8);
        repeat (n)
          access(CMD_WRITE, 7'($urandom_range(ADDR_BUF_LO, ADDR_BUF_HI)), byte_t'($urandom));
        access(CMD_READ, ADDR_MODE, byte_t'($urandom));
      end else begin
        // noise: anything the fields allow, leaning toward live addresses
        n = $urandom_range(4, 12);
        repeat (n) begin
          roll = $urandom_range(0, 99);
          if (roll < 30)
            access(cmd_t'($urandom_range(0, 1)),
                   7'($urandom_range(ADDR_BUF_LO, ADDR_BUF_HI)), byte_t'($urandom));
          else if (roll < 40)
            access(cmd_t'($urandom_range(0, 1)), ADDR_COMMAND, byte_t'($urandom));
          else if (roll < 48)
            access(CMD_WRITE, ADDR_IRQ_CLR,
                   ($urandom_range(0, 1) != 0) ? IRQ_CLR_KEY : byte_t'($urandom));
          else
            access(cmd_t'($urandom_range(0, 1)), 7'($urandom), byte_t'($urandom));
        end
      end
      seq_no++;
    end

    drain_replies();
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // downstream: runs of ready, short and long stalls, one long hold on request
  initial begin : downstream
    int unsigned run_left;
    int unsigned stall_left;
    int unsigned roll;
    out_ready  = 1'b0;
    run_left   = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (run_left != 0) begin
        out_ready <= 1'b1;
        run_left--;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 65) run_left = $urandom_range(1, 12);
        else if (roll < 95) stall_left = $urandom_range(1, 3);
        else stall_left = $urandom_range(10, 40);
      end
    end
  end

  // scoreboard: predict on every accepted access beat, check every reply beat
  // against the oldest owed reply; inputs settle at the falling edge so
  // everything read here is the value before this rising edge
  always @(posedge clk) begin : scoreboard
    reply_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        want = apply_access(cmd_t'(cmd), addr, wdata);
        if (typed_known) want = typed_reply;
        replies_due.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          $display("%0t ns: reply beat with nothing owed, kind %0h", $time, kind);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          compare_field("kind", 64'(want.kind), 64'(kind));
          compare_field("rdata", 64'(want.rdata), 64'(rdata));
          compare_field("frame_id", 64'(want.frame.id), 64'(frame_id));
          compare_field("frame_len", 64'(want.frame.len), 64'(frame_len));
          compare_field("frame_data", want.frame.data, frame_data);
          compare_field("irq_level", 64'(want.irq), 64'(irq_level));
        end
      end
    end
  end

  // hard stop if the handshakes hang
  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
